// File: rtl/tccw_pkg.sv
// Shared types, codes and default sizes for the text console character writer.
package tccw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  // Field widths
  localparam int KIND_W = 2;
  localparam int CODE_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Character codes
  localparam logic [CODE_W-1:0] CH_BS        = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CODE_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CODE_W-1:0] CH_PRINT_MAX = 8'h7F;

  // Attribute after reset
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // Input word
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [IDX_W-1:0]  cursor_index;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } out_word_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL,
    ST_DONE
  } ctrl_state_e;

  // Scan counter operations
  typedef enum logic [1:0] {
    SCAN_HOLD,
    SCAN_INC,
    SCAN_ZERO,
    SCAN_LAST_ROW
  } scan_op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     accept;
    scan_op_e scan_op;
    logic     copy_rd;
    logic     copy_wr;
    logic     fill_wr;
    logic     fill_reset;
    logic     out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              put_scroll;
    logic              scan_last_copy;
    logic              scan_last_fill;
    logic              out_free;
  } sts_t;

endpackage

// File: rtl/tccw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tccw_ctrl.sv
// Controller state machine: sequences items, screen copy and fill passes.
module tccw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tccw_pkg::sts_t sts_i,
  output tccw_pkg::cmd_t cmd_o
);

  tccw_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tccw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tccw_pkg::ST_INIT: begin
        if (sts_i.scan_last_fill) state_d = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.kind)
            tccw_pkg::KIND_PUT: begin
              state_d = sts_i.put_scroll ? tccw_pkg::ST_COPY_RD : tccw_pkg::ST_DONE;
            end
            tccw_pkg::KIND_CLEAR: state_d = tccw_pkg::ST_FILL;
            default:              state_d = tccw_pkg::ST_DONE;
          endcase
        end
      end
      tccw_pkg::ST_COPY_RD: state_d = tccw_pkg::ST_COPY_WR;
      tccw_pkg::ST_COPY_WR: begin
        state_d = sts_i.scan_last_copy ? tccw_pkg::ST_FILL : tccw_pkg::ST_COPY_RD;
      end
      tccw_pkg::ST_FILL: begin
        if (sts_i.scan_last_fill) state_d = tccw_pkg::ST_DONE;
      end
      tccw_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = tccw_pkg::ST_IDLE;
      end
      default: state_d = tccw_pkg::ST_INIT;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tccw_pkg::ST_INIT: begin
        cmd_o.fill_wr    = 1'b1;
        cmd_o.fill_reset = 1'b1;
        cmd_o.scan_op    = sts_i.scan_last_fill ? tccw_pkg::SCAN_ZERO : tccw_pkg::SCAN_INC;
      end
      tccw_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      tccw_pkg::ST_COPY_RD: begin
        cmd_o.copy_rd = 1'b1;
      end
      tccw_pkg::ST_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.scan_op = sts_i.scan_last_copy ? tccw_pkg::SCAN_LAST_ROW : tccw_pkg::SCAN_INC;
      end
      tccw_pkg::ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        cmd_o.scan_op = sts_i.scan_last_fill ? tccw_pkg::SCAN_ZERO : tccw_pkg::SCAN_INC;
      end
      tccw_pkg::ST_DONE: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: rtl/tccw_dpath.sv
// Datapath: cursor, attribute, scan counter, screen memory and result register.
module tccw_dpath #(
  parameter int COLUMNS   = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tccw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tccw_pkg::DEF_TAB_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tccw_pkg::cmd_t               cmd_i,
  output tccw_pkg::sts_t               sts_o,
  input  tccw_pkg::in_word_t           in_word_i,
  input  logic                         cfg_valid_i,
  input  logic [tccw_pkg::ATTR_W-1:0]  cfg_data_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output tccw_pkg::out_word_t          out_word_o
);

  localparam int CELL_COUNT    = COLUMNS * ROWS;
  localparam int AW            = $clog2(CELL_COUNT);
  localparam int CW            = $clog2(COLUMNS);
  localparam int CXW           = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RW            = $clog2(ROWS);
  localparam int RXW           = $clog2(ROWS + 1);
  localparam int PW            = $clog2(TAB_WIDTH);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
  localparam int COPY_LAST     = LAST_ROW_BASE - 1;
  localparam int IDX_W         = tccw_pkg::IDX_W;
  localparam int CELL_W        = tccw_pkg::CELL_W;

  logic [CW-1:0]               col_q;
  logic [RW-1:0]               row_q;
  logic [PW-1:0]               phase_q;
  logic [tccw_pkg::ATTR_W-1:0] attr_q;
  logic [AW-1:0]               scan_q;
  logic [AW-1:0]               cur_idx_q;
  logic                        rd_hit_q;
  logic                        scrolled_q;
  logic                        out_valid_q;
  tccw_pkg::out_word_t         out_word_q;

  logic [AW-1:0]               idx_c;
  logic [CXW-1:0]              col_x;
  logic [RXW-1:0]              row_x;
  logic [PW-1:0]               phase_x;
  logic                        printable;
  logic                        scroll_n;
  logic                        in_range;
  logic                        out_free;
  logic                        is_put;
  logic                        is_read;
  logic                        is_clear;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [CELL_W-1:0]           ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [CELL_W-1:0]           ram_rdata;

  assign is_put   = in_word_i.kind == tccw_pkg::KIND_PUT;
  assign is_read  = in_word_i.kind == tccw_pkg::KIND_READ;
  assign is_clear = in_word_i.kind == tccw_pkg::KIND_CLEAR;
  assign in_range = 32'(in_word_i.cell_index) < 32'(CELL_COUNT);

  // Linear cursor position
  assign idx_c = AW'(AW'(row_q) * AW'(COLUMNS) + AW'(col_q));

  // Cursor movement for one character
  always_comb begin
    col_x     = CXW'(col_q);
    row_x     = RXW'(row_q);
    phase_x   = phase_q;
    printable = (in_word_i.char_code >= tccw_pkg::CH_BLANK) &&
                (in_word_i.char_code <= tccw_pkg::CH_PRINT_MAX);
    case (in_word_i.char_code)
      tccw_pkg::CH_BS: begin
        if (col_q != '0) begin
          col_x   = CXW'(col_q) - CXW'(1);
          phase_x = (phase_q == '0) ? PW'(TAB_WIDTH - 1) : phase_q - PW'(1);
        end
      end
      tccw_pkg::CH_TAB: begin
        col_x   = CXW'(col_q) + CXW'(TAB_WIDTH) - CXW'(phase_q);
        phase_x = '0;
      end
      tccw_pkg::CH_CR: begin
        col_x   = '0;
        phase_x = '0;
      end
      tccw_pkg::CH_LF: begin
        col_x   = '0;
        row_x   = RXW'(row_q) + RXW'(1);
        phase_x = '0;
      end
      default: begin
        if (printable) begin
          col_x   = CXW'(col_q) + CXW'(1);
          phase_x = (phase_q == PW'(TAB_WIDTH - 1)) ? '0 : phase_q + PW'(1);
        end
      end
    endcase
    // Wrap past the last column
    if (col_x >= CXW'(COLUMNS)) begin
      col_x   = '0;
      row_x   = row_x + RXW'(1);
      phase_x = '0;
    end
    scroll_n = row_x == RXW'(ROWS);
  end

  // Cursor and attribute registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
      attr_q  <= tccw_pkg::RESET_ATTR;
    end else begin
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
      if (cmd_i.accept && is_put) begin
        col_q   <= CW'(col_x);
        row_q   <= scroll_n ? RW'(ROWS - 1) : RW'(row_x);
        phase_q <= phase_x;
      end else if (cmd_i.accept && is_clear) begin
        col_q   <= '0;
        row_q   <= '0;
        phase_q <= '0;
      end
    end
  end

  // Scan counter for copy and fill passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      case (cmd_i.scan_op)
        tccw_pkg::SCAN_INC:      scan_q <= scan_q + AW'(1);
        tccw_pkg::SCAN_ZERO:     scan_q <= '0;
        tccw_pkg::SCAN_LAST_ROW: scan_q <= AW'(LAST_ROW_BASE);
        default:                 scan_q <= scan_q;
      endcase
    end
  end

  // Track cursor address, latch item flags
  always_ff @(posedge clk_i) begin
    cur_idx_q <= idx_c;
    if (cmd_i.accept) begin
      rd_hit_q   <= is_read && in_range;
      scrolled_q <= is_put && scroll_n;
    end
  end

  // Memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_q;
    ram_wdata = cmd_i.fill_reset ? {tccw_pkg::RESET_ATTR, tccw_pkg::CH_BLANK}
                                 : {attr_q, tccw_pkg::CH_BLANK};
    ram_re    = 1'b0;
    ram_raddr = AW'(in_word_i.cell_index);
    if (cmd_i.accept && is_put && printable) begin
      ram_we    = 1'b1;
      ram_waddr = cur_idx_q;
      ram_wdata = {attr_q, in_word_i.char_code};
    end
    if (cmd_i.copy_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end
    if (cmd_i.fill_wr) begin
      ram_we = 1'b1;
    end
    if (cmd_i.accept && is_read && in_range) begin
      ram_re = 1'b1;
    end
    if (cmd_i.copy_rd) begin
      ram_re    = 1'b1;
      ram_raddr = scan_q + AW'(COLUMNS);
    end
  end

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register: hold while stalled
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_word_q.cursor_index <= IDX_W'(idx_c);
      out_word_q.cell_value   <= rd_hit_q ? ram_rdata : '0;
      out_word_q.scrolled     <= scrolled_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Status to controller
  assign sts_o.kind           = in_word_i.kind;
  assign sts_o.put_scroll     = scroll_n;
  assign sts_o.scan_last_copy = scan_q == AW'(COPY_LAST);
  assign sts_o.scan_last_fill = scan_q == AW'(CELL_COUNT - 1);
  assign sts_o.out_free       = out_free;

endmodule

// File: rtl/text_console_char_writer.sv
// Top level of the text console character writer.
//
// Input channel (in_valid_i / in_stall_o / in_word_i) carries one word per
// item: put a character, read one cell, or clear the screen and home the
// cursor. Output channel (out_valid_o / out_stall_i / out_word_o) returns
// exactly one word per item with the cursor position after the item, the
// cell read (zero otherwise) and a scroll flag.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// text attribute; it is always ready.
// Sequencing: an item is accepted in the idle state, and its result is loaded
// into the output register in the done state, once that register is free.
// No new item is taken until the result of the last one has been loaded.
// A put that scrolls first copies each row up by one, alternating a read and
// a write state per cell, then blanks the bottom row; a clear runs a fill
// pass over the whole screen. Both fills write blanks with the current attribute.
// After reset a clearing pass over every cell writes blank cells
// with attribute 0x0F; in_stall_o stays high meanwhile, configuration
// writes are still taken. A stalled result holds in the output register;
// the next item is still taken, and its result waits until that slot frees.
module text_console_char_writer #(
  parameter int COLUMNS   = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tccw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tccw_pkg::DEF_TAB_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tccw_pkg::in_word_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tccw_pkg::out_word_t         out_word_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tccw_pkg::ATTR_W-1:0] cfg_data_i
);

  tccw_pkg::cmd_t cmd;
  tccw_pkg::sts_t sts;

  // Attribute writes are never held off
  assign cfg_ready_o = 1'b1;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccw_dpath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule
